@@ hw/rtl/wkms_pkg.sv @@
package wkms_pkg;

    // Field widths
    localparam int TAG_W  = 16;
    localparam int CNT_W  = 20;
    localparam int RATE_W = 20;
    localparam int PROD_W = CNT_W + RATE_W;
    localparam int KEY_W  = PROD_W + 1;

    // Default capacity of the record store
    localparam int MAX_RECORDS_DEF = 64;

    // Configuration register indexes
    localparam logic REG_TOKEN_RATE = 1'b0;
    localparam logic REG_BILL_RATE  = 1'b1;

    // One input record
    typedef struct packed {
        logic [TAG_W-1:0] record_tag;
        logic [CNT_W-1:0] token_count;
        logic [CNT_W-1:0] bill_count;
        logic             last_record;
    } t_item;

    // One sorted result
    typedef struct packed {
        logic [TAG_W-1:0] sorted_tag;
        logic [KEY_W-1:0] sort_key;
        logic             last_out;
    } t_result;

    // Stored record: tag and key
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } t_rec;

endpackage

@@ hw/rtl/wkms_ram.sv @@
module wkms_ram #(
    parameter int WIDTH = 57,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

@@ hw/rtl/weighted_key_merge_sort.sv @@
// Channel   | Direction | Transfer condition                   | Payload
// ----------+-----------+--------------------------------------+----------------------------
// record    | in        | start && !busy                       | i_item (wkms_pkg::t_item)
// result    | out       | o_result_valid, one result per cycle | o_result (wkms_pkg::t_result)
// config    | in        | psel && penable && pwrite (pready=1) | pwdata at paddr 0 / 4
//
// Records load one per cycle while idle; the key passes a registered multiply stage and
// is written to the store from the product registers. After the last record: a drain
// state, then a stack-driven top-down merge sort, where each run is merged into
// scratch and copied back under the sequencer, then the N results back to back;
// busy falls in the cycle of the final result. Reset is synchronous (count, rates,
// sequencer, valid flags); the receiver cannot stall results.
module weighted_key_merge_sort #(
    parameter int MAX_RECORDS = wkms_pkg::MAX_RECORDS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // record channel
    input  logic                   start,
    output logic                   busy,
    input  wkms_pkg::t_item        i_item,
    // result channel
    output logic                   o_result_valid,
    output wkms_pkg::t_result      o_result,
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    import wkms_pkg::*;

    localparam int AW   = $clog2(MAX_RECORDS);
    localparam int CW   = $clog2(MAX_RECORDS + 1);
    localparam int SD   = AW;
    localparam int SIW  = (SD > 1) ? $clog2(SD) : 1;
    localparam int SPW  = $clog2(SD + 1);
    localparam int RECW = $bits(t_rec);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DRAIN = 8'b0000_0010,
        S_SEQ   = 8'b0000_0100,
        S_MRD   = 8'b0000_1000,
        S_MCMP  = 8'b0001_0000,
        S_CRD   = 8'b0010_0000,
        S_CWR   = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    typedef enum logic [1:0] {
        PH_LEFT  = 2'd0,
        PH_RIGHT = 2'd1,
        PH_MERGE = 2'd2
    } t_phase;

    // One pending run of the recursion
    typedef struct packed {
        logic [AW-1:0] base;
        logic [CW-1:0] len;
        t_phase        phase;
    } t_frame;

    // Configuration registers
    logic [RATE_W-1:0] r_token_rate;
    logic [RATE_W-1:0] r_bill_rate;

    // Sequencer registers and next values
    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [SPW-1:0] r_sp, n_sp;
    t_frame         r_stack [SD];
    t_frame         n_stack [SD];
    logic [AW-1:0]  r_base, n_base;
    logic [CW-1:0]  r_len, n_len;
    logic [CW-1:0]  r_mid, n_mid;
    logic [CW-1:0]  r_lp, n_lp;
    logic [CW-1:0]  r_rp, n_rp;
    logic [CW-1:0]  r_i, n_i;
    logic [AW-1:0]  r_k, n_k;

    // Load stage
    logic              r_s1_v;
    logic [AW-1:0]     r_s1_addr;
    logic [TAG_W-1:0]  r_s1_tag;
    logic [PROD_W-1:0] r_prod_tok;
    logic [PROD_W-1:0] r_prod_bill;

    // Output stage
    logic r_res_v;
    logic r_res_last;

    // Memory ports
    logic          a_we;
    logic [AW-1:0] a_waddr;
    t_rec          a_wdata;
    logic [AW-1:0] a0_raddr, a1_raddr;
    t_rec          a0_rdata, a1_rdata;
    logic          b_we;
    t_rec          b_wdata;
    logic [AW-1:0] b_addr;
    t_rec          b_rdata;

    logic           w_accept;
    logic           w_cfg_wr;
    logic [SIW-1:0] top_idx;
    logic [SIW-1:0] push_idx;
    t_frame         top_f;
    logic [CW-1:0]  half_len;
    logic [CW-1:0]  right_len;
    logic           l_ok, r_ok, take_left;
    logic           emit_last;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_BILL_RATE) ? 32'(r_bill_rate) : 32'(r_token_rate);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_rate <= RATE_W'(1);
            r_bill_rate  <= RATE_W'(1);
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_TOKEN_RATE) begin
                r_token_rate <= pwdata[RATE_W-1:0];
            end else begin
                r_bill_rate <= pwdata[RATE_W-1:0];
            end
        end
    end

    // Load stage: products registered, sum formed at the store write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= w_accept && (r_count < CW'(MAX_RECORDS));
        end
        r_s1_addr   <= AW'(r_count);
        r_s1_tag    <= i_item.record_tag;
        r_prod_tok  <= PROD_W'(i_item.token_count) * PROD_W'(r_bill_rate);
        r_prod_bill <= PROD_W'(i_item.bill_count) * PROD_W'(r_token_rate);
    end

    // Stack and merge helpers
    assign top_idx   = SIW'(r_sp - 1'b1);
    assign push_idx  = SIW'(r_sp);
    assign top_f     = r_stack[top_idx];
    assign half_len  = top_f.len >> 1;
    assign right_len = top_f.len - half_len;
    assign l_ok      = (r_lp < r_mid);
    assign r_ok      = (r_rp < r_len);
    assign take_left = (l_ok && r_ok) ? (a0_rdata.key < a1_rdata.key) : l_ok;
    assign emit_last = (r_k == AW'(r_count - 1'b1));

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_sp    = r_sp;
        n_stack = r_stack;
        n_base  = r_base;
        n_len   = r_len;
        n_mid   = r_mid;
        n_lp    = r_lp;
        n_rp    = r_rp;
        n_i     = r_i;
        n_k     = r_k;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (r_count < CW'(MAX_RECORDS)) begin
                        n_count = r_count + 1'b1;
                    end
                    if (i_item.last_record) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                // last record is written to the store on this edge
                n_k = '0;
                if (r_count >= CW'(2)) begin
                    n_stack[0] = '{base: '0, len: r_count, phase: PH_LEFT};
                    n_sp       = SPW'(1);
                    n_state    = S_SEQ;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SEQ: begin
                if (r_sp == '0) begin
                    n_k     = '0;
                    n_state = S_EMIT;
                end else begin
                    case (top_f.phase)
                        PH_LEFT: begin
                            n_stack[top_idx].phase = PH_RIGHT;
                            if (half_len >= CW'(2)) begin
                                n_stack[push_idx] = '{base: top_f.base, len: half_len,
                                                      phase: PH_LEFT};
                                n_sp = r_sp + 1'b1;
                            end
                        end
                        PH_RIGHT: begin
                            n_stack[top_idx].phase = PH_MERGE;
                            if (right_len >= CW'(2)) begin
                                n_stack[push_idx] = '{
                                    base:  AW'(CW'(top_f.base) + half_len),
                                    len:   right_len,
                                    phase: PH_LEFT};
                                n_sp = r_sp + 1'b1;
                            end
                        end
                        default: begin
                            n_base  = top_f.base;
                            n_len   = top_f.len;
                            n_mid   = half_len;
                            n_lp    = '0;
                            n_rp    = half_len;
                            n_i     = '0;
                            n_state = S_MRD;
                        end
                    endcase
                end
            end
            S_MRD: begin
                n_state = S_MCMP;
            end
            S_MCMP: begin
                if (take_left) begin
                    n_lp = r_lp + 1'b1;
                end else begin
                    n_rp = r_rp + 1'b1;
                end
                if (r_i == r_len - 1'b1) begin
                    n_i     = '0;
                    n_state = S_CRD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_MRD;
                end
            end
            S_CRD: begin
                n_state = S_CWR;
            end
            S_CWR: begin
                if (r_i == r_len - 1'b1) begin
                    n_sp    = r_sp - 1'b1;
                    n_state = S_SEQ;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_CRD;
                end
            end
            S_EMIT: begin
                n_k = r_k + 1'b1;
                if (emit_last) begin
                    n_count = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_sp    <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_sp    <= n_sp;
        end
        r_stack <= n_stack;
        r_base  <= n_base;
        r_len   <= n_len;
        r_mid   <= n_mid;
        r_lp    <= n_lp;
        r_rp    <= n_rp;
        r_i     <= n_i;
        r_k     <= n_k;
    end

    // Record store port selection: load writes, or copy back from scratch
    assign a_we     = r_s1_v || (r_state == S_CWR);
    assign a_waddr  = r_s1_v ? r_s1_addr : AW'(CW'(r_base) + r_i);
    assign a_wdata  = r_s1_v ? t_rec'{tag: r_s1_tag,
                                      key: KEY_W'(r_prod_tok) + KEY_W'(r_prod_bill)}
                             : b_rdata;
    assign a0_raddr = (r_state == S_EMIT) ? r_k : AW'(CW'(r_base) + r_lp);
    assign a1_raddr = AW'(CW'(r_base) + r_rp);

    // Scratch: merge writes, copy reads
    assign b_we    = (r_state == S_MCMP);
    assign b_wdata = take_left ? a0_rdata : a1_rdata;
    assign b_addr  = AW'(r_i);

    // Two copies of the record store give the two read ports of a merge step
    wkms_ram #(.WIDTH(RECW), .DEPTH(MAX_RECORDS)) u_store_l (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (a0_raddr),
        .o_rdata (a0_rdata)
    );

    wkms_ram #(.WIDTH(RECW), .DEPTH(MAX_RECORDS)) u_store_r (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (a1_raddr),
        .o_rdata (a1_rdata)
    );

    wkms_ram #(.WIDTH(RECW), .DEPTH(MAX_RECORDS)) u_scratch (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_addr),
        .i_wdata (b_wdata),
        .i_raddr (b_addr),
        .o_rdata (b_rdata)
    );

    // Result strobe is registered from the emit read, in the cycle after it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_v <= 1'b0;
        end else begin
            r_res_v <= (r_state == S_EMIT);
        end
        r_res_last <= emit_last;
    end

    assign o_result_valid      = r_res_v;
    assign o_result.sorted_tag = a0_rdata.tag;
    assign o_result.sort_key   = a0_rdata.key;
    assign o_result.last_out   = r_res_last;

    // Recursion never goes deeper than the stack
    a_stack_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(SD))
        else $error("merge stack overflow");

    // Merge pointers stay inside their halves
    a_merge_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MCMP) |-> (r_lp <= r_mid) && (r_rp <= r_len) && (r_mid < r_len))
        else $error("merge pointer out of range");

    // A result only follows an emit read
    a_res_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == S_EMIT))
        else $error("result strobe without emit read");

    // A last record transfer makes the block busy
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.last_record) |=> busy)
        else $error("last record did not start sorting");

    // The final result closes the set
    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.last_out) |-> (r_state == S_IDLE) && (r_count == '0))
        else $error("final result while set still open");

endmodule
